@@ hw/rtl/cpe_pkg.sv @@
// Shared types and constants for the Chebyshev polynomial evaluation unit.
// No dependencies; imported by the controller, the datapath and the top level.
package cpe_pkg;

   localparam int XW = 18;   // sample width
   localparam int VW = 32;   // result width
   localparam int OW = 6;    // degree width
   localparam int PW = XW + VW + 1;   // width of 2*x*T(k-1)

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EMIT = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_CALC = 4'b1000
   } state_type;

   typedef struct packed {
      logic          load;     // take a new sample, set T0
      logic          step_x;   // set T1 = x
      logic          mul;      // register 2*x*T(k-1)
      logic          calc;     // form Tk from the product
      logic          emit;     // move the current value to the result register
      logic [OW-1:0] order;
      logic          last;
   } cmd_type;

endpackage

@@ hw/rtl/cpe_ctrl.sv @@
// Sequencer for the Chebyshev evaluation unit: request/result handshake,
// degree counter and datapath commands. Depends on cpe_pkg.
module cpe_ctrl
   import cpe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  logic [OW-1:0] degree,
   output cmd_type       cmd
);

   state_type     state_ff, state_in;
   logic [OW-1:0] k_ff, k_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept, out_free, emit, is_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (state_ff == ST_EMIT) && out_free;
   assign is_last   = (k_ff == degree);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load   = accept;
      cmd.step_x = emit && !is_last && (k_ff == '0);
      cmd.mul    = (state_ff == ST_MUL);
      cmd.calc   = (state_ff == ST_CALC);
      cmd.emit   = emit;
      cmd.order  = k_ff;
      cmd.last   = is_last;
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               k_in     = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
                  // T1 is the sample itself, no multiply needed
                  state_in = (k_ff == '0) ? ST_EMIT : ST_MUL;
               end
            end
         end
         ST_MUL:  state_in = ST_CALC;
         ST_CALC: state_in = ST_EMIT;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("result register not marked valid after emit");

   a_mul_calc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> (state_ff == ST_CALC))
      else $error("multiply not followed by calc");

   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (k_ff <= degree))
      else $error("degree counter past configured degree");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EMIT) && (k_ff == '0))
      else $error("new request did not restart at T0");

endmodule

@@ hw/rtl/cpe_datapath.sv @@
// Recurrence datapath: sample hold, T(k-1)/T(k-2) registers, multiplier,
// saturating subtract and result register. Depends on cpe_pkg.
module cpe_datapath
   import cpe_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic                 clock,
   input  cmd_type              cmd,
   input  logic signed [XW-1:0] req_x,
   output logic signed [VW-1:0] rsp_value,
   output logic [OW-1:0]        rsp_order,
   output logic                 rsp_last,
   output logic                 rsp_saturated
);

   localparam logic [VW-1:0] One = VW'(64'd1 << FRAC_BITS);

   logic signed [XW-1:0]   point_ff, point_in;
   logic signed [VW-1:0]   prev_ff, prev_in;
   logic signed [VW-1:0]   prev_prev_ff, prev_prev_in;
   logic [PW-1:0]          prod_ff, prod_in;
   logic                   sat_ff, sat_in;
   logic signed [VW-1:0]   value_ff;
   logic [OW-1:0]          order_ff;
   logic                   last_ff, rsp_sat_ff;

   logic signed [PW-2:0]   mult;
   logic signed [PW:0]     wide, shifted, pp_ext, diff;
   logic                   over_hi, over_lo;
   logic [VW-1:0]          clipped;

   assign mult    = point_ff * prev_ff;
   assign wide    = {prod_ff[PW-1], prod_ff};
   assign shifted = wide >>> FRAC_BITS;
   assign pp_ext  = {{(PW+1-VW){prev_prev_ff[VW-1]}}, prev_prev_ff};
   assign diff    = shifted - pp_ext;
   // out of range when the bits above the 32-bit sign differ from it
   assign over_hi = !diff[PW] && (diff[PW-1:VW-1] != '0);
   assign over_lo = diff[PW] && (diff[PW-1:VW-1] != '1);

   always_comb begin
      if (over_hi) begin
         clipped = {1'b0, {(VW-1){1'b1}}};
      end else if (over_lo) begin
         clipped = {1'b1, {(VW-1){1'b0}}};
      end else begin
         clipped = diff[VW-1:0];
      end
   end

   always_comb begin
      point_in     = point_ff;
      prev_in      = prev_ff;
      prev_prev_in = prev_prev_ff;
      prod_in      = prod_ff;
      sat_in       = sat_ff;
      if (cmd.load) begin
         point_in     = req_x;
         prev_in      = One;
         prev_prev_in = '0;
         sat_in       = 1'b0;
      end else if (cmd.step_x) begin
         prev_prev_in = prev_ff;
         prev_in      = {{(VW-XW){point_ff[XW-1]}}, point_ff};
         sat_in       = 1'b0;
      end else if (cmd.mul) begin
         prod_in = {mult, 1'b0};
      end else if (cmd.calc) begin
         prev_prev_in = prev_ff;
         prev_in      = clipped;
         sat_in       = over_hi || over_lo;
      end
   end

   always_ff @(posedge clock) begin
      point_ff     <= point_in;
      prev_ff      <= prev_in;
      prev_prev_ff <= prev_prev_in;
      prod_ff      <= prod_in;
      sat_ff       <= sat_in;
      if (cmd.emit) begin
         value_ff   <= prev_ff;
         order_ff   <= cmd.order;
         last_ff    <= cmd.last;
         rsp_sat_ff <= sat_ff;
      end
   end

   assign rsp_value     = value_ff;
   assign rsp_order     = order_ff;
   assign rsp_last      = last_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

@@ hw/rtl/chebyshev_polynomial_eval_unit.sv @@
// Chebyshev polynomial evaluation unit, first kind, fixed point.
// Top level: degree register, controller and datapath. Depends on cpe_pkg.
//
// Usage:
//  - Request channel (req_valid/req_stall, req_x): one sample x, signed with
//    FRAC_BITS fraction bits. A request is taken only while the unit is idle.
//  - Result channel (rsp_valid/rsp_stall): T0(x) .. TD(x) in ascending order,
//    each with its degree on rsp_order, rsp_last on TD and rsp_saturated when
//    the value was clipped to the 32-bit limits. D is csr_wdata as last
//    written with csr_we, clamped to MAX_ORDER; reset value 7.
//  - Timing: once a request is taken the sequencer enters its emit state,
//    which loads T0 into the result register; T1 is the sample itself, and
//    every further value passes through multiply, subtract/saturate and load
//    result register, paced by the single multiplier of the recurrence. The
//    next request is taken once TD is in the result register.
//  - A stalled result holds its register and the sequencer waits on it.
//  - Reset clears the sequencer and result valid and sets the degree to 7.
module chebyshev_polynomial_eval_unit
   import cpe_pkg::*;
#(
   parameter int MAX_ORDER = 63,
   parameter int FRAC_BITS = 16
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [XW-1:0] req_x,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [VW-1:0] rsp_value,
   output logic [OW-1:0]        rsp_order,
   output logic                 rsp_last,
   output logic                 rsp_saturated,
   input  logic                 csr_we,
   input  logic [OW-1:0]        csr_wdata
);

   localparam logic [OW-1:0] MaxOrderC = OW'(MAX_ORDER);
   localparam logic [OW-1:0] DegreeReset = OW'(7);

   logic [OW-1:0] degree_ff, degree_in;
   logic [OW-1:0] degree_eff;
   cmd_type       cmd;

   assign degree_in  = csr_we ? csr_wdata : degree_ff;
   assign degree_eff = (degree_ff > MaxOrderC) ? MaxOrderC : degree_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DegreeReset;
      end else begin
         degree_ff <= degree_in;
      end
   end

   cpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .degree    (degree_eff),
      .cmd       (cmd)
   );

   cpe_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .req_x         (req_x),
      .rsp_value     (rsp_value),
      .rsp_order     (rsp_order),
      .rsp_last      (rsp_last),
      .rsp_saturated (rsp_saturated)
   );

endmodule
